>>> rtl/tsvp_pkg.sv
// Shared types, constants and helpers for the timed-step valve positioner.
`timescale 1ns / 1ps
`default_nettype none
package tsvp_pkg;

	localparam int TIMER_BITS = 16;
	localparam int CFG_W      = 16;
	localparam int STEP_W     = 8;
	localparam int TICK_W     = 16;
	localparam int CFG_ADDR_W = 2;
	localparam int S_DATA_W   = 8;
	localparam int M_DATA_W   = 16;

	localparam logic [STEP_W-1:0] STEPS_DEFAULT = STEP_W'(5);
	localparam logic [STEP_W-1:0] STEPS_MIN     = STEP_W'(3);
	localparam logic [STEP_W-1:0] STEP_MAX      = {STEP_W{1'b1}};
	localparam logic [TICK_W-1:0] TRAVEL_RESET  = TICK_W'(120);
	localparam logic [TICK_W-1:0] PULSE_RESET   = TICK_W'(24);

	typedef logic [TIMER_BITS-1:0] timer_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_STEP_COUNT  = 2'd0,
		REG_FULL_TRAVEL = 2'd1,
		REG_STEP_PULSE  = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_HOMING  = 2'd1,
		PH_OPENING = 2'd2,
		PH_CLOSING = 2'd3
	} phase_t;

	typedef struct packed {
		logic              busy_res;
		logic              homed;
		logic [STEP_W-1:0] position;
		logic              close_drive;
		logic              open_drive;
	} result_t;

	function automatic timer_t timer_load(input logic [TICK_W-1:0] v);
		timer_t t;
		t = TIMER_BITS'(v);
		return (t == '0) ? timer_t'(1) : t;
	endfunction

endpackage
`default_nettype wire

>>> rtl/tsvp_core.sv
// Valve state registers, configuration registers and per-transaction update logic.
`timescale 1ns / 1ps
`default_nettype none
module tsvp_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [tsvp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [tsvp_pkg::CFG_W-1:0]       cfg_wdata,
	input  wire logic                             step_en,
	input  wire logic                             req_type,
	input  wire logic [tsvp_pkg::STEP_W-1:0]      target_step,
	output tsvp_pkg::result_t                     res
);

	logic [tsvp_pkg::STEP_W-1:0] step_count_q;
	logic [tsvp_pkg::TICK_W-1:0] full_travel_q;
	logic [tsvp_pkg::TICK_W-1:0] step_pulse_q;

	logic [tsvp_pkg::STEP_W-1:0] pos_q, pos_d;
	logic                        homed_q, homed_d;
	logic [tsvp_pkg::STEP_W-1:0] tgt_q, tgt_d;
	tsvp_pkg::phase_t            phase_q, phase_d;
	tsvp_pkg::timer_t            timer_q, timer_d;

	logic [tsvp_pkg::STEP_W-1:0] eff_steps;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_count_q  <= tsvp_pkg::STEPS_DEFAULT;
			full_travel_q <= tsvp_pkg::TRAVEL_RESET;
			step_pulse_q  <= tsvp_pkg::PULSE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				tsvp_pkg::REG_STEP_COUNT:  step_count_q  <= cfg_wdata[tsvp_pkg::STEP_W-1:0];
				tsvp_pkg::REG_FULL_TRAVEL: full_travel_q <= cfg_wdata[tsvp_pkg::TICK_W-1:0];
				tsvp_pkg::REG_STEP_PULSE:  step_pulse_q  <= cfg_wdata[tsvp_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign eff_steps = (step_count_q < tsvp_pkg::STEPS_MIN) ? tsvp_pkg::STEPS_DEFAULT
	                                                       : step_count_q;

	always_comb begin
		pos_d   = pos_q;
		homed_d = homed_q;
		tgt_d   = tgt_q;
		phase_d = phase_q;
		timer_d = timer_q;
		if (req_type) begin
			if (!homed_q && phase_q == tsvp_pkg::PH_IDLE) begin
				phase_d = tsvp_pkg::PH_HOMING;
				timer_d = tsvp_pkg::timer_load(full_travel_q);
			end
			if (target_step != '0) begin
				tgt_d = (target_step > eff_steps) ? eff_steps : target_step;
			end
		end else if (phase_q != tsvp_pkg::PH_IDLE) begin
			if (timer_q <= tsvp_pkg::timer_t'(1)) begin
				unique case (phase_q)
					tsvp_pkg::PH_HOMING: begin
						pos_d   = tsvp_pkg::STEP_W'(1);
						homed_d = 1'b1;
					end
					tsvp_pkg::PH_OPENING: begin
						if (pos_q != tsvp_pkg::STEP_MAX) pos_d = pos_q + tsvp_pkg::STEP_W'(1);
					end
					tsvp_pkg::PH_CLOSING: begin
						if (pos_q != '0) pos_d = pos_q - tsvp_pkg::STEP_W'(1);
					end
					default: ;
				endcase
				phase_d = tsvp_pkg::PH_IDLE;
				timer_d = '0;
			end else begin
				timer_d = timer_q - tsvp_pkg::timer_t'(1);
			end
		end
		if (phase_d == tsvp_pkg::PH_IDLE && homed_d && tgt_d != '0) begin
			if (tgt_d > pos_d) begin
				phase_d = tsvp_pkg::PH_OPENING;
				timer_d = tsvp_pkg::timer_load(step_pulse_q);
			end else if (tgt_d < pos_d) begin
				phase_d = tsvp_pkg::PH_CLOSING;
				timer_d = tsvp_pkg::timer_load(step_pulse_q);
			end
		end
		res.open_drive  = (phase_d == tsvp_pkg::PH_OPENING);
		res.close_drive = (phase_d == tsvp_pkg::PH_HOMING) || (phase_d == tsvp_pkg::PH_CLOSING);
		res.position    = pos_d;
		res.homed       = homed_d;
		res.busy_res    = (phase_d != tsvp_pkg::PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			homed_q <= 1'b0;
			tgt_q   <= '0;
			phase_q <= tsvp_pkg::PH_IDLE;
			timer_q <= '0;
		end else if (step_en) begin
			pos_q   <= pos_d;
			homed_q <= homed_d;
			tgt_q   <= tgt_d;
			phase_q <= phase_d;
			timer_q <= timer_d;
		end
	end

	a_drives_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.open_drive && res.close_drive))
		else $error("open and close drive on together");

	a_homed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		homed_q |=> homed_q)
		else $error("homed flag cleared");

	a_pos_before_home: assert property (@(posedge clk) disable iff (!arst_n)
		!homed_q |-> (pos_q == '0))
		else $error("position moved before homing");

	a_pos_after_home: assert property (@(posedge clk) disable iff (!arst_n)
		homed_q |-> (pos_q != '0))
		else $error("position left range after homing");

	a_homing_once: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == tsvp_pkg::PH_HOMING) |-> !homed_q)
		else $error("homing while already homed");

endmodule
`default_nettype wire

>>> rtl/timed_step_valve_positioner.sv
// Top level of the timed-step valve positioner: stream handshake, input and result registers.
//
// Usage:
//   s_axis carries one transaction per request: tuser = req_type (0 = time tick,
//   1 = set target), tdata = target_step. Every accepted transaction yields exactly
//   one result on m_axis: tdata holds open_drive, close_drive, position, homed and
//   busy_res, showing the valve state after that transaction.
//   Registers are written through cfg_wr_en / cfg_addr / cfg_wdata; the user must write them
//   only while no transaction is in flight, as the block itself does not enforce this.
// Path: an accepted transaction is captured in the input register; its result is then
//   captured in the result register, which may wait while m_axis is stalled.
// Throughput: one transaction per cycle unless m_axis stalls; the state update is a
//   single pass of compare, decrement and select logic between input and result registers.
// Reset: arst_n clears the valve state (position 0, not homed, idle, no target)
//   and loads register defaults (5 steps, 120 travel ticks, 24 pulse ticks).
// Stall: while m_axis_tready is low a valid result holds in its register; the input register
//   still takes one transaction, then s_axis_tready drops until the result leaves.
`timescale 1ns / 1ps
`default_nettype none
module timed_step_valve_positioner (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [tsvp_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [tsvp_pkg::CFG_W-1:0]       cfg_wdata,
	input  wire logic                             s_axis_tvalid,
	output      logic                             s_axis_tready,
	// [7:0] target_step
	input  wire logic [tsvp_pkg::S_DATA_W-1:0]    s_axis_tdata,
	// [0] req_type
	input  wire logic                             s_axis_tuser,
	output      logic                             m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// [0] open_drive, [1] close_drive, [9:2] position, [10] homed, [11] busy_res, [15:12] zero
	output      logic [tsvp_pkg::M_DATA_W-1:0]    m_axis_tdata
);

	logic                        valid_s1;
	logic                        req_s1;
	logic [tsvp_pkg::STEP_W-1:0] tgt_s1;
	logic                        adv_s1;
	tsvp_pkg::result_t           res;
	tsvp_pkg::result_t           res_q;
	logic                        m_valid_q;

	assign adv_s1        = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1 <= s_axis_tuser;
			tgt_s1 <= s_axis_tdata[tsvp_pkg::STEP_W-1:0];
		end
	end

	tsvp_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.step_en     (adv_s1),
		.req_type    (req_s1),
		.target_step (tgt_s1),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_axis_tready) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = tsvp_pkg::M_DATA_W'(res_q);

endmodule
`default_nettype wire
